>>> rtl/gn2o_pkg.sv
// Shared types, widths and constants for the octave gradient noise block.
// Used by the multiplier, the divider and the top level; depends on nothing else.
package gn2o_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int MAX_OCTAVES = 8;
    localparam int FRAC_BITS   = 16;

    localparam int FB = FRAC_BITS;
    localparam int XW = FB + 1;      // fraction or fraction minus one, signed
    localparam int GW = FB + 3;      // gradient dot product, signed
    localparam int LW = FB + 4;      // interpolation values, signed
    localparam int FW = FB + 4;      // fade intermediate terms, unsigned
    localparam int MW = 33;          // shared multiplier operand width
    localparam int PW = 2 * MW;      // shared multiplier product width
    localparam int TW = LW + 28;     // weighted octave sum, signed
    localparam int AW = 24;          // amplitude
    localparam int SW = AW + 1;      // amplitude sum
    localparam int PAW = 40;         // position and frequency width
    localparam int CW = $clog2(TW);  // divider iteration counter

    localparam logic [FW-1:0] FADE_A = FW'(15 * (1 << FB));
    localparam logic [FW-1:0] FADE_B = FW'(10 * (1 << FB));
    localparam logic signed [XW-1:0] ONE_X = XW'(1 << FB);

    localparam logic [PAW-1:0] UNIT_Q16 = PAW'(1 << 16);
    localparam logic [AW-1:0]  AMP_ONE  = AW'(1 << 16);

    localparam logic signed [TW:0] Q_MAX = (TW+1)'(131071);
    localparam logic signed [TW:0] Q_MIN = -(TW+1)'(131072);

    // Configuration register indexes.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_IW-1:0] CFG_INV_SCALE   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_OCTAVES     = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_PERSISTENCE = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_LACUNARITY  = 2'd3;

    // Input word actions.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Gradient code boundaries and the two codes that reuse x.
    localparam logic [3:0] G_U_Y  = 4'd8;
    localparam logic [3:0] G_V_Y  = 4'd4;
    localparam logic [3:0] G_VX_A = 4'd12;
    localparam logic [3:0] G_VX_B = 4'd14;

    typedef struct packed {
        logic          start;
        logic [TW-1:0] num;
        logic [SW-1:0] den;
    } t_div_req;

    function automatic logic signed [GW-1:0] grad_q(
        input logic [3:0]           h,
        input logic signed [XW-1:0] x,
        input logic signed [XW-1:0] y
    );
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        u = (h < G_U_Y) ? GW'(x) : GW'(y);
        if (h < G_V_Y) begin
            v = GW'(y);
        end else if (h == G_VX_A || h == G_VX_B) begin
            v = GW'(x);
        end else begin
            v = '0;
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

>>> rtl/gn2o_mul.sv
// Shared signed multiplier with a registered product.
// Depends on gn2o_pkg for operand and product widths.
module gn2o_mul (
    input  logic                                 i_clk,
    input  logic signed [gn2o_pkg::MW-1:0]       i_a,
    input  logic signed [gn2o_pkg::MW-1:0]       i_b,
    output logic signed [gn2o_pkg::PW-1:0]       o_p
);
    import gn2o_pkg::*;

    logic signed [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> rtl/gn2o_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gn2o_pkg for widths and the request struct.
module gn2o_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gn2o_pkg::t_div_req         i_req,
    output logic                       o_done,
    output logic [gn2o_pkg::TW-1:0]    o_quo
);
    import gn2o_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_den;
    logic [TW-1:0] r_q;

    logic [SW:0]   trial;
    logic          ge;
    logic [SW:0]   diff;

    always_comb begin
        trial = {r_rem, r_q[TW-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(TW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[SW-1:0] : trial[SW-1:0];
            r_q   <= {r_q[TW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

>>> rtl/gradient_noise_2d_octaves.sv
// Top level of the octave gradient noise block: sequencer, permutation table,
// configuration registers and output register. Uses gn2o_pkg, gn2o_mul, gn2o_div.
//
// Usage. The input channel (i_valid / o_ready) carries one word at a time.
// A word with i_action low writes i_table_value into permutation entry
// i_table_index and produces no result; the block stays ready. A word with
// i_action high samples the noise at (i_coord_x, i_coord_y), signed Q16.16,
// and produces one result word on the output channel (o_valid / i_ready):
// the normalized octave sum in signed Q1.16, saturated.
// All 256 table entries must be loaded before the first sample.
// A sample runs coordinate scaling, then 22 shared-multiplier steps per
// octave, then the one-bit-per-cycle divider, which runs and reports, then
// one hand-off. The single multiplier is used once per cycle. o_ready is
// low while a sample is in flight.
// The result sits in an output register, so the next word is taken while a
// result still waits; if the receiver stalls until the next sample is done,
// that sample holds in its final step until the register frees up.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. A synchronous active-low reset returns the registers to
// their defaults and drops o_valid; table contents stay undefined until loaded.
module gradient_noise_2d_octaves (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_action,
    input  logic signed [31:0]                i_coord_x,
    input  logic signed [31:0]                i_coord_y,
    input  logic [7:0]                        i_table_index,
    input  logic [7:0]                        i_table_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [17:0]                o_noise_value,
    input  logic                              i_cfg_we,
    input  logic [gn2o_pkg::CFG_IW-1:0]       i_cfg_idx,
    input  logic [gn2o_pkg::CFG_DW-1:0]       i_cfg_data
);
    import gn2o_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCALE = 5'b00010,
        S_OCT   = 5'b00100,
        S_DIV   = 5'b01000,
        S_POST  = 5'b10000
    } t_state;

    // Steps of one octave; each step takes one multiplier product and
    // issues the next.
    typedef enum logic [4:0] {
        OS_XLL, OS_XHL, OS_XLH, OS_YLL, OS_YHL, OS_YLH,
        OS_TXX, OS_T2X, OS_T3X, OS_INX,
        OS_TYY, OS_T2Y, OS_T3Y, OS_INY,
        OS_LA, OS_LB, OS_AMP, OS_LV, OS_FLO, OS_NA, OS_FHI, OS_FUP
    } t_ostep;

    t_state r_state, n_state;
    t_ostep r_step;
    logic [1:0] r_sstep;
    logic [3:0] r_oct;
    logic [3:0] r_nocts;

    // Configuration.
    logic [31:0] r_inv;
    logic [3:0]  r_ocfg;
    logic [16:0] r_pers;
    logic [23:0] r_lac;

    // Permutation table.
    logic [7:0] r_perm [TABLE_SIZE];
    logic [7:0] r_rd;
    logic [7:0] rd_addr;

    // Datapath registers.
    logic signed [31:0]    r_inx, r_iny;
    logic [PAW-1:0]        r_sx, r_sy, r_freq, r_acc;
    logic [FB-1:0]         r_fx, r_fy, r_t3;
    logic [7:0]            r_cx, r_cy;
    logic [8:0]            r_pa, r_pb;
    logic [3:0]            r_h00, r_h10, r_h01, r_h11;
    logic signed [GW-1:0]  r_g00, r_g10, r_g01, r_g11;
    logic [XW-1:0]         r_u, r_v;
    logic signed [LW-1:0]  r_r0, r_r1, r_noise;
    logic [AW-1:0]         r_amp, r_apn;
    logic [SW-1:0]         r_asum;
    logic signed [TW-1:0]  r_total;
    logic [43:0]           r_facc;
    logic                  r_neg;
    logic signed [TW:0]    r_quo;
    logic signed [17:0]    r_out;
    logic                  r_o_valid;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  prod;
    t_div_req              div_req;
    logic                  div_done;
    logic [TW-1:0]         div_quo;

    logic                  in_acc, load_acc, samp_acc, last_oct, out_free;
    logic [PAW-1:0]        pos_sum;
    logic [FW-1:0]         six_x, six_y, inner;
    logic signed [XW-1:0]  fx_s, fy_s, fxm_s, fym_s;
    logic [64:0]           freq_wide;
    logic [48:0]           freq_new;
    logic signed [TW:0]    quo_s;
    logic [3:0]            ocl;

    assign in_acc   = i_valid && o_ready;
    assign load_acc = in_acc && (i_action == ACT_LOAD);
    assign samp_acc = in_acc && (i_action == ACT_SAMPLE);
    assign last_oct = (r_oct == r_nocts - 4'd1);
    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_noise_value = r_out;

    // The octave count register clamps into the supported range.
    assign ocl = (r_ocfg == 4'd0) ? 4'd1 :
                 (r_ocfg > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : r_ocfg;

    // Position low 40 bits are built from three 20-bit partial products.
    assign pos_sum = r_acc + {prod[19:0], 20'b0};

    assign six_x = (FW'(r_fx) << 2) + (FW'(r_fx) << 1);
    assign six_y = (FW'(r_fy) << 2) + (FW'(r_fy) << 1);
    assign inner = FADE_B - prod[FB+FW-1:FB];

    assign fx_s  = XW'(r_fx);
    assign fy_s  = XW'(r_fy);
    assign fxm_s = fx_s - ONE_X;
    assign fym_s = fy_s - ONE_X;

    assign freq_wide = {1'b0, prod[43:0], 20'b0} + 65'(r_facc);
    assign freq_new  = freq_wide[64:16];

    assign quo_s = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    assign div_req.start = (r_state == S_OCT) && (r_step == OS_FUP) && last_oct;
    assign div_req.num   = r_total[TW-1] ? TW'(-r_total) : TW'(r_total);
    assign div_req.den   = r_asum;

    gn2o_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    gn2o_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Multiplier operand and table address selection.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        rd_addr = r_cx;
        if (r_state == S_SCALE) begin
            mul_a = MW'(r_sstep == 2'd0 ? r_inx : r_iny);
            mul_b = MW'(r_inv);
        end else begin
            case (r_step)
                OS_XLL: begin mul_a = MW'(r_sx[19:0]);  mul_b = MW'(r_freq[19:0]);  end
                OS_XHL: begin mul_a = MW'(r_sx[39:20]); mul_b = MW'(r_freq[19:0]);  end
                OS_XLH: begin mul_a = MW'(r_sx[19:0]);  mul_b = MW'(r_freq[39:20]); end
                OS_YLL: begin mul_a = MW'(r_sy[19:0]);  mul_b = MW'(r_freq[19:0]);  end
                OS_YHL: begin mul_a = MW'(r_sy[39:20]); mul_b = MW'(r_freq[19:0]);  end
                OS_YLH: begin mul_a = MW'(r_sy[19:0]);  mul_b = MW'(r_freq[39:20]); end
                OS_TXX: begin
                    mul_a = MW'(r_fx); mul_b = MW'(r_fx); rd_addr = r_cx;
                end
                OS_T2X: begin
                    mul_a = MW'(prod[2*FB-1:FB]); mul_b = MW'(r_fx);
                    rd_addr = r_cx + 8'd1;
                end
                OS_T3X: begin
                    mul_a = MW'(r_fx); mul_b = MW'(FADE_A - six_x); rd_addr = r_pa[7:0];
                end
                OS_INX: begin
                    mul_a = MW'(r_t3); mul_b = MW'(inner); rd_addr = r_pb[7:0];
                end
                OS_TYY: begin
                    mul_a = MW'(r_fy); mul_b = MW'(r_fy); rd_addr = r_pa[7:0] + 8'd1;
                end
                OS_T2Y: begin
                    mul_a = MW'(prod[2*FB-1:FB]); mul_b = MW'(r_fy);
                    rd_addr = r_pb[7:0] + 8'd1;
                end
                OS_T3Y: begin mul_a = MW'(r_fy); mul_b = MW'(FADE_A - six_y); end
                OS_INY: begin mul_a = MW'(r_t3); mul_b = MW'(inner); end
                OS_LA:  begin mul_a = MW'(r_u); mul_b = MW'(LW'(r_g10) - LW'(r_g00)); end
                OS_LB:  begin mul_a = MW'(r_u); mul_b = MW'(LW'(r_g11) - LW'(r_g01)); end
                OS_AMP: begin mul_a = MW'(r_amp); mul_b = MW'(r_pers); end
                OS_LV:  begin mul_a = MW'(r_v); mul_b = MW'(r_r1 - r_r0); end
                OS_FLO: begin mul_a = MW'(r_freq[19:0]); mul_b = MW'(r_lac); end
                OS_NA:  begin mul_a = MW'(r_noise); mul_b = MW'(r_amp); end
                OS_FHI: begin mul_a = MW'(r_freq[39:20]); mul_b = MW'(r_lac); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // Permutation table: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_perm[i_table_index] <= i_table_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_perm[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= 32'd65536;
            r_ocfg <= 4'd4;
            r_pers <= 17'd32768;
            r_lac  <= 24'd131072;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_SCALE:   r_inv  <= i_cfg_data;
                CFG_OCTAVES:     r_ocfg <= i_cfg_data[3:0];
                CFG_PERSISTENCE: r_pers <= i_cfg_data[16:0];
                CFG_LACUNARITY:  r_lac  <= i_cfg_data[23:0];
                default:         r_inv  <= r_inv;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (samp_acc) n_state = S_SCALE;
            S_SCALE: if (r_sstep == 2'd2) n_state = S_OCT;
            S_OCT:   if (r_step == OS_FUP && last_oct) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_POST;
            S_POST:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_step    <= OS_XLL;
            r_sstep   <= 2'd0;
            r_oct     <= 4'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_POST && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (samp_acc) begin
                r_sstep <= 2'd0;
                r_step  <= OS_XLL;
                r_oct   <= 4'd0;
            end else if (r_state == S_SCALE) begin
                r_sstep <= r_sstep + 2'd1;
            end else if (r_state == S_OCT) begin
                if (r_step == OS_FUP) begin
                    r_step <= OS_XLL;
                    r_oct  <= r_oct + 4'd1;
                end else begin
                    r_step <= t_ostep'(r_step + 5'd1);
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (samp_acc) begin
            r_inx   <= i_coord_x;
            r_iny   <= i_coord_y;
            r_nocts <= ocl;
            r_freq  <= UNIT_Q16;
            r_amp   <= AMP_ONE;
            r_asum  <= '0;
            r_total <= '0;
        end
        if (r_state == S_SCALE) begin
            if (r_sstep == 2'd1) r_sx <= prod[55:16];
            if (r_sstep == 2'd2) r_sy <= prod[55:16];
        end
        if (r_state == S_OCT) begin
            case (r_step)
                OS_XHL: r_acc <= prod[PAW-1:0];
                OS_XLH: r_acc <= pos_sum;
                OS_YLL: begin
                    r_fx <= pos_sum[31:32-FB];
                    r_cx <= pos_sum[39:32];
                end
                OS_YHL: r_acc <= prod[PAW-1:0];
                OS_YLH: r_acc <= pos_sum;
                OS_TXX: begin
                    r_fy <= pos_sum[31:32-FB];
                    r_cy <= pos_sum[39:32];
                end
                OS_T2X: r_pa <= 9'(r_rd) + 9'(r_cy);
                OS_T3X: begin
                    r_t3 <= prod[2*FB-1:FB];
                    r_pb <= 9'(r_rd) + 9'(r_cy);
                end
                OS_INX: r_h00 <= r_rd[3:0];
                OS_TYY: begin
                    r_u   <= prod[FB+XW-1:FB];
                    r_h10 <= r_rd[3:0];
                end
                OS_T2Y: r_h01 <= r_rd[3:0];
                OS_T3Y: begin
                    r_t3  <= prod[2*FB-1:FB];
                    r_h11 <= r_rd[3:0];
                end
                OS_INY: begin
                    r_g00 <= grad_q(r_h00, fx_s, fy_s);
                    r_g10 <= grad_q(r_h10, fxm_s, fy_s);
                    r_g01 <= grad_q(r_h01, fx_s, fym_s);
                    r_g11 <= grad_q(r_h11, fxm_s, fym_s);
                end
                OS_LA:  r_v  <= prod[FB+XW-1:FB];
                OS_LB:  r_r0 <= LW'(r_g00) + prod[FB+LW-1:FB];
                OS_AMP: r_r1 <= LW'(r_g01) + prod[FB+LW-1:FB];
                OS_LV:  r_apn <= prod[16+AW-1:16];
                OS_FLO: r_noise <= r_r0 + prod[FB+LW-1:FB];
                OS_NA:  r_facc <= prod[43:0];
                OS_FHI: begin
                    r_total <= r_total + prod[TW-1:0];
                    r_asum  <= r_asum + SW'(r_amp);
                    r_amp   <= r_apn;
                end
                OS_FUP: begin
                    r_freq <= (|freq_new[48:40]) ? {PAW{1'b1}} : freq_new[PAW-1:0];
                    r_neg  <= r_total[TW-1];
                end
                default: r_acc <= r_acc;
            endcase
        end
        if (r_state == S_DIV && div_done) begin
            r_quo <= quo_s >>> (FB - 16);
        end
        if (r_state == S_POST && out_free) begin
            if (r_quo > Q_MAX) begin
                r_out <= 18'sd131071;
            end else if (r_quo < Q_MIN) begin
                r_out <= -18'sd131072;
            end else begin
                r_out <= r_quo[17:0];
            end
        end
    end

endmodule

>>> rtl/gn2o_chk.sv
// Port-level checker for the octave gradient noise block, bound to the top.
// Depends only on the top level's port names.
module gn2o_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               i_action,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [17:0] o_noise_value
);

    // Reset always empties the output register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // A waiting result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_noise_value))
        else $error("result word changed or dropped while stalled");

    // A sample word occupies the block.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_action |=> !o_ready)
        else $error("block still ready after taking a sample word");

    // A table load leaves the block ready.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_action |=> o_ready)
        else $error("block not ready after a table load");

endmodule

bind gradient_noise_2d_octaves gn2o_chk u_gn2o_chk (.*);
